/* rtl/region_table_access_check_macros.svh */
// Assertion helpers used by the region table RTL.
`ifndef REGION_TABLE_ACCESS_CHECK_MACROS_SVH
`define REGION_TABLE_ACCESS_CHECK_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define RTAC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RTAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rtac_pkg.sv */
package rtac_pkg;

  localparam int unsigned MaxRegions = 16;
  localparam int unsigned AddrW      = 64;
  localparam int unsigned FlagW      = 5;

  typedef enum logic [1:0] {
    CmdAdd    = 2'd0,
    CmdRemove = 2'd1,
    CmdCheck  = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusBadRange  = 2'd1,
    StatusFull      = 2'd2,
    StatusNotFound  = 2'd3
  } status_e;

  localparam logic [FlagW-1:0] FlagRead  = 5'b00001;
  localparam logic [FlagW-1:0] FlagWrite = 5'b00010;
  localparam logic [FlagW-1:0] FlagExec  = 5'b00100;

  typedef struct packed {
    logic [AddrW-1:0] start_addr;
    logic [AddrW-1:0] end_addr;
    logic [FlagW-1:0] flags;
  } entry_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    cmd_e             cmd;
    entry_t           req_entry;
    logic [AddrW-1:0] probe_addr;
    logic             add_en;
    logic             shift_en;
  } cell_ctrl_t;

endpackage

/* rtl/region_table_access_check.sv */
// Region table with access check.
// Requests enter on the s_axis channel: tuser carries the command (add,
// remove, check), tdata the region bounds, flags, probe address and fault
// kind. Every request gives exactly one result on the m_axis channel with
// status, allowed, hit and the matched region's flags.
// The table is a row of cells, one region per cell, oldest in cell 0. Each
// cell compares its own region against the request; a priority stage picks
// the newest match, and a remove shifts every cell above it down by one.
// After a request is accepted, the cell compare, the priority stage and
// commit are registered in turn, and the result is then valid. One request
// is in flight at a time, so a new request is taken only once the last one
// has committed.
// A finished result sits in the output register; the next request is
// accepted while it waits, and commit holds in place while the receiver
// stalls with the register still full.
// Reset empties the table at once; region contents are only read once valid.
`include "region_table_access_check_macros.svh"

module region_table_access_check
  import rtac_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [63:0] region_start, [127:64] region_end, [132:128] region_flags,
  // [196:133] probe_address, [197] fault_instr, [198] fault_write
  input  logic [199:0] s_axis_tdata_i,
  // [1:0] command
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [1:0] status, [2] allowed, [3] hit, [8:4] hit_flags
  output logic [15:0]  m_axis_tdata_o
);

  typedef enum logic [1:0] {
    Idle,
    Match,
    Scan,
    Commit
  } state_e;

  typedef struct packed {
    cmd_e             cmd;
    entry_t           req_entry;
    logic [AddrW-1:0] probe_addr;
    logic             fault_instr;
    logic             fault_write;
  } req_t;

  state_e                state_q;
  req_t                  req_q;
  logic                  bad_q;
  logic [MaxRegions-1:0] higher_q;
  logic                  out_valid_q;
  logic [15:0]           out_data_q;

  cell_ctrl_t            ctrl;
  entry_t                entry_w [MaxRegions];
  logic [MaxRegions-1:0] valid_w;
  logic [MaxRegions-1:0] match_w;
  logic [MaxRegions-1:0] higher_w;
  logic [MaxRegions-1:0] sel_w;

  logic                  accept;
  logic                  out_free;
  logic                  commit_fire;
  logic                  found;
  logic                  full;
  logic [FlagW-1:0]      hit_flags;
  logic [FlagW-1:0]      need;
  logic                  allowed;
  status_e               status;
  logic [15:0]           result;

  assign s_axis_tready_o = (state_q == Idle);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign commit_fire     = (state_q == Commit) && out_free;

  assign found = |match_w;
  assign full  = valid_w[MaxRegions-1];
  assign sel_w = match_w & ~higher_q;

  assign ctrl.cmd        = req_q.cmd;
  assign ctrl.req_entry  = req_q.req_entry;
  assign ctrl.probe_addr = req_q.probe_addr;
  assign ctrl.add_en     = commit_fire && (req_q.cmd == CmdAdd) && !bad_q && !full;
  assign ctrl.shift_en   = commit_fire && (req_q.cmd == CmdRemove) && !bad_q && found;

  for (genvar k = 0; k < MaxRegions; k++) begin : g_cell
    entry_t above_entry;
    logic   above_valid;
    logic   below_valid;

    if (k == MaxRegions - 1) begin : g_top
      assign above_entry = '0;
      assign above_valid = 1'b0;
    end else begin : g_mid
      assign above_entry = entry_w[k+1];
      assign above_valid = valid_w[k+1];
    end

    if (k == 0) begin : g_base
      assign below_valid = 1'b1;
    end else begin : g_up
      assign below_valid = valid_w[k-1];
    end

    rtac_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .below_valid_i  (below_valid),
      .above_entry_i  (above_entry),
      .above_valid_i  (above_valid),
      .higher_match_i (higher_q[k]),
      .entry_o        (entry_w[k]),
      .valid_o        (valid_w[k]),
      .match_o        (match_w[k])
    );
  end

  rtac_prio u_prio (
    .match_i  (match_w),
    .higher_o (higher_w)
  );

  always_comb begin
    hit_flags = '0;
    for (int unsigned k = 0; k < MaxRegions; k++) begin
      if (sel_w[k]) begin
        hit_flags = hit_flags | entry_w[k].flags;
      end
    end
  end

  always_comb begin
    if (req_q.fault_instr) begin
      need = FlagExec;
    end else if (req_q.fault_write) begin
      need = FlagWrite;
    end else begin
      need = FlagRead;
    end
  end

  assign allowed = found && (hit_flags != '0) && ((hit_flags & need) == need);

  always_comb begin
    status = StatusOk;
    result = '0;
    case (req_q.cmd)
      CmdAdd: begin
        if (bad_q) begin
          status = StatusBadRange;
        end else if (full) begin
          status = StatusFull;
        end
        result[1:0] = status;
      end
      CmdRemove: begin
        if (bad_q) begin
          status = StatusBadRange;
        end else if (!found) begin
          status = StatusNotFound;
        end
        result[1:0] = status;
      end
      CmdCheck: begin
        result[2]   = allowed;
        result[3]   = found;
        result[8:4] = hit_flags;
      end
      default: result = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Idle;
      out_valid_q <= 1'b0;
    end else begin
      if (commit_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        Idle:   if (accept) state_q <= Match;
        Match:  state_q <= Scan;
        Scan:   state_q <= Commit;
        Commit: if (out_free) state_q <= Idle;
        default: state_q <= Idle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.cmd                  <= cmd_e'(s_axis_tuser_i);
      req_q.req_entry.start_addr <= s_axis_tdata_i[63:0];
      req_q.req_entry.end_addr   <= s_axis_tdata_i[127:64];
      req_q.req_entry.flags      <= s_axis_tdata_i[132:128];
      req_q.probe_addr           <= s_axis_tdata_i[196:133];
      req_q.fault_instr          <= s_axis_tdata_i[197];
      req_q.fault_write          <= s_axis_tdata_i[198];
    end
    if (state_q == Match) begin
      bad_q <= (req_q.req_entry.start_addr >= req_q.req_entry.end_addr);
    end
    if (state_q == Scan) begin
      higher_q <= higher_w;
    end
    if (commit_fire) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `RTAC_ASSERT_ALWAYS(a_valid_prefix, (valid_w & (valid_w + 1'b1)) == '0,
                      "valid entries are not a prefix")
  `RTAC_ASSERT_ALWAYS(a_miss_clean,
                      !out_valid_q || out_data_q[3] || (out_data_q[8:2] == '0),
                      "result without hit carries flags")
  `RTAC_ASSERT_NEXT(a_remove_shrinks, ctrl.shift_en,
                    $countones(valid_w) + 1 == $past($countones(valid_w)),
                    "remove did not drop one entry")
  `RTAC_ASSERT_NEXT(a_add_grows, ctrl.add_en,
                    $countones(valid_w) == $past($countones(valid_w)) + 1,
                    "add did not place one entry")

endmodule

/* rtl/rtac_cell.sv */
module rtac_cell
  import rtac_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       below_valid_i,
  input  entry_t     above_entry_i,
  input  logic       above_valid_i,
  input  logic       higher_match_i,
  output entry_t     entry_o,
  output logic       valid_o,
  output logic       match_o
);

  entry_t entry_q, entry_d;
  logic   valid_q, valid_d;
  logic   match_q, match_d;
  logic   first_free;

  assign first_free = !valid_q && below_valid_i;

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (ctrl_i.add_en && first_free) begin
      entry_d = ctrl_i.req_entry;
      valid_d = 1'b1;
    end else if (ctrl_i.shift_en && !higher_match_i) begin
      // close the gap left by the removed entry
      entry_d = above_entry_i;
      valid_d = above_valid_i;
    end
  end

  always_comb begin
    case (ctrl_i.cmd)
      CmdRemove: match_d = valid_q
                           && (entry_q.start_addr == ctrl_i.req_entry.start_addr)
                           && (entry_q.end_addr == ctrl_i.req_entry.end_addr);
      CmdCheck:  match_d = valid_q
                           && (entry_q.start_addr <= ctrl_i.probe_addr)
                           && (ctrl_i.probe_addr <= entry_q.end_addr);
      default:   match_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;
  assign match_o = match_q;

endmodule

/* rtl/rtac_prio.sv */
module rtac_prio
  import rtac_pkg::*;
(
  input  logic [MaxRegions-1:0] match_i,
  output logic [MaxRegions-1:0] higher_o
);

  logic [MaxRegions-1:0] at_or_above;

  // smear each match down toward slot 0 in log steps
  always_comb begin
    at_or_above = match_i;
    for (int unsigned s = 1; s < MaxRegions; s = s * 2) begin
      at_or_above = at_or_above | (at_or_above >> s);
    end
    higher_o = at_or_above >> 1;
  end

endmodule

/* verif/region_table_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the region table, keeps its own copy of the table,
// and compares every result with the oldest outstanding prediction.
module region_table_checker
  import rtac_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [199:0] s_tdata_i,
  input  logic [1:0]   s_tuser_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [15:0]  m_tdata_i,
  output int           fail_count_o,
  output int           pending_o
);

  typedef struct packed {
    status_e          status;
    logic             allowed;
    logic             hit;
    logic [FlagW-1:0] hit_flags;
  } access_result_t;

  logic [AddrW-1:0] tab_lo [MaxRegions];
  logic [AddrW-1:0] tab_hi [MaxRegions];
  logic [FlagW-1:0] tab_fl [MaxRegions];
  int               tab_used;
  access_result_t   result_q [$];
  int               mismatches;

  // Apply one request to the table copy and return the result it must give.
  function automatic access_result_t apply_request(cmd_e cmd, logic [199:0] d);
    logic [AddrW-1:0] lo, hi, probe;
    logic [FlagW-1:0] fl, need;
    access_result_t   r;
    int               idx;
    int               i;
    lo    = d[63:0];
    hi    = d[127:64];
    fl    = d[132:128];
    probe = d[196:133];
    r     = '0;
    idx   = -1;
    case (cmd)
      CmdAdd: begin
        if (lo >= hi) begin
          r.status = StatusBadRange;
        end else if (tab_used >= MaxRegions) begin
          r.status = StatusFull;
        end else begin
          tab_lo[tab_used] = lo;
          tab_hi[tab_used] = hi;
          tab_fl[tab_used] = fl;
          tab_used++;
        end
      end
      CmdRemove: begin
        if (lo >= hi) begin
          r.status = StatusBadRange;
        end else begin
          for (i = tab_used - 1; i >= 0 && idx < 0; i--) begin
            if (tab_lo[i] == lo && tab_hi[i] == hi) idx = i;
          end
          if (idx < 0) begin
            r.status = StatusNotFound;
          end else begin
            // close the gap, newer regions move down one slot
            for (i = idx; i < tab_used - 1; i++) begin
              tab_lo[i] = tab_lo[i + 1];
              tab_hi[i] = tab_hi[i + 1];
              tab_fl[i] = tab_fl[i + 1];
            end
            tab_used--;
          end
        end
      end
      CmdCheck: begin
        need = d[197] ? FlagExec : (d[198] ? FlagWrite : FlagRead);
        for (i = tab_used - 1; i >= 0 && idx < 0; i--) begin
          if (tab_lo[i] <= probe && probe <= tab_hi[i]) idx = i;
        end
        if (idx >= 0) begin
          r.hit       = 1'b1;
          r.hit_flags = tab_fl[idx];
          r.allowed   = (tab_fl[idx] != '0) && ((tab_fl[idx] & need) == need);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    access_result_t want, got;
    if (!rst_ni) begin
      tab_used = 0;
      result_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = '{status_e'(m_tdata_i[1:0]), m_tdata_i[2], m_tdata_i[3], m_tdata_i[8:4]};
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no request outstanding: %h", $realtime, m_tdata_i);
        end else begin
          want = result_q.pop_front();
          if (got.status !== want.status || got.allowed !== want.allowed ||
              got.hit !== want.hit || got.hit_flags !== want.hit_flags) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: result mismatch: exp st=%0d al=%0b hit=%0b fl=%h,",
                        " got st=%0d al=%0b hit=%0b fl=%h"},
                       $realtime, want.status, want.allowed, want.hit, want.hit_flags,
                       got.status, got.allowed, got.hit, got.hit_flags);
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        result_q.push_back(apply_request(cmd_e'(s_tuser_i), s_tdata_i));
      fail_count_o <= mismatches;
      pending_o <= result_q.size();
    end
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top
  import rtac_pkg::*;
();

  typedef struct {
    logic [AddrW-1:0] lo;
    logic [AddrW-1:0] hi;
  } span_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [199:0] s_tdata = '0;
  logic [1:0]   s_tuser = CmdNone;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [15:0]  m_tdata;
  int           fail_count;
  int           pending;

  int           sent = 0;
  int           burst_left = 0;
  int           gap_max = 4;
  int           hold_req = 0;
  span_t        known [$];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  region_table_access_check uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  region_table_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one request and hold it until accepted; pace the sender in bursts.
  task automatic offer(cmd_e cmd, logic [63:0] lo, logic [63:0] hi, logic [4:0] fl,
                       logic [63:0] probe, logic fi, logic fw);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {1'b0, fw, fi, probe, fl, hi, lo};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      if (gap_max > 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      end
    end
  endtask

  task automatic add_region(logic [63:0] lo, logic [63:0] hi, logic [4:0] fl);
    offer(CmdAdd, lo, hi, fl, rand64(), 1'($urandom_range(0, 1)),
          1'($urandom_range(0, 1)));
  endtask

  task automatic remove_region(logic [63:0] lo, logic [63:0] hi);
    offer(CmdRemove, lo, hi, 5'($urandom_range(0, 31)), rand64(),
          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic check_access(logic [63:0] probe, logic fi, logic fw);
    offer(CmdCheck, rand64(), rand64(), 5'($urandom_range(0, 31)), probe, fi, fw);
  endtask

  // Stop offering until every outstanding result has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  // Receiver: segments of random readiness, plus a long hold-off on request.
  initial begin
    int seg;
    int mode;
    int hold_seen;
    hold_seen = 0;
    @(posedge rst_ni);
    forever begin
      seg  = $urandom_range(5, 60);
      mode = $urandom_range(0, 3);
      repeat (seg) begin
        if (hold_req != hold_seen) begin
          hold_seen = hold_req;
          m_tready <= 1'b0;
          repeat (300) @(posedge clk_i);
        end
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 4) == 0);
          default: m_tready <= ~m_tready;
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [63:0] base, lo, hi, probe, span;
    int          add_w, rem_w, pick, k, steps;
    span_t       sp;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, full-range region, bad ranges, guard, precedence
    check_access('0, 1'b1, 1'b0);
    add_region('0, '1, 5'b11111);
    check_access('0, 1'b0, 1'b0);
    check_access('1, 1'b1, 1'b0);
    check_access(64'h8000_0000_0000_0000, 1'b0, 1'b1);
    add_region(64'd500, 64'd500, 5'b00111);
    add_region('1, '0, 5'b00111);
    add_region(64'd100, 64'd200, 5'b00000);
    check_access(64'd150, 1'b0, 1'b0);
    add_region(64'd150, 64'd160, FlagWrite);
    check_access(64'd155, 1'b0, 1'b1);
    check_access(64'd160, 1'b0, 1'b0);
    check_access(64'd150, 1'b1, 1'b1);
    check_access(64'd161, 1'b0, 1'b1);
    remove_region(64'd150, 64'd160);
    remove_region(64'd150, 64'd160);
    remove_region(64'd7, 64'd7);
    remove_region('1, 64'd1);
    offer(CmdNone, rand64(), rand64(), 5'b11111, rand64(), 1'b1, 1'b1);
    remove_region('0, '1);
    check_access(64'd100, 1'b0, 1'b0);
    remove_region(64'd100, 64'd200);
    check_access(64'd150, 1'b1, 1'b0);
    drain();

    // long receiver hold-off while the sender keeps offering
    hold_req++;

    // random: phases that fill, drain or mix the table around a window
    while (sent < 1325) begin
      base    = ($urandom_range(0, 3) == 0) ? rand64() : {32'h0, $urandom} << $urandom_range(0, 31);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      case ($urandom_range(0, 2))
        0: begin add_w = 65; rem_w = 5;  end
        1: begin add_w = 5;  rem_w = 60; end
        default: begin add_w = 35; rem_w = 25; end
      endcase
      k = $urandom_range(0, 11);
      if (k == 0) hold_req++;
      if (k == 1) drain();
      steps = $urandom_range(10, 40);
      repeat (steps) begin
        pick = $urandom_range(0, 99);
        if (pick < add_w) begin
          lo = base + $urandom_range(0, 4000);
          hi = ($urandom_range(0, 19) == 0) ? rand64() : lo + $urandom_range(0, 2000);
          add_region(lo, hi, 5'($urandom_range(0, 31)));
          if (lo < hi) begin
            known.push_back('{lo, hi});
            if (known.size() > 40) void'(known.pop_front());
          end
        end else if (pick < add_w + rem_w) begin
          if (known.size() > 0 && $urandom_range(0, 99) < 85) begin
            k = $urandom_range(0, known.size() - 1);
            sp = known[k];
            known.delete(k);
            remove_region(sp.lo, sp.hi);
          end else begin
            lo = base + $urandom_range(0, 4000);
            remove_region(lo, lo + $urandom_range(0, 2000));
          end
        end else if (pick < 95) begin
          if (known.size() > 0 && $urandom_range(0, 99) < 80) begin
            sp = known[$urandom_range(0, known.size() - 1)];
            span = sp.hi - sp.lo;
            case ($urandom_range(0, 5))
              0: probe = sp.lo;
              1: probe = sp.hi;
              2: probe = sp.lo - 1;
              3: probe = sp.hi + 1;
              default: probe = sp.lo + ((span == '1) ? rand64() : rand64() % (span + 1));
            endcase
          end else begin
            probe = ($urandom_range(0, 1) == 0) ? rand64() : base + $urandom_range(0, 6000);
          end
          check_access(probe, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          offer(cmd_e'($urandom_range(0, 3)), rand64(), rand64(), 5'($urandom_range(0, 31)),
                rand64(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/rtac_pkg.sv
rtl/rtac_cell.sv
rtl/rtac_prio.sv
rtl/region_table_access_check.sv
verif/region_table_checker.sv
verif/tb_top.sv
